// ----- rtl/aie_pkg.sv -----
// shared types, constants and helpers for the arp / icmp echo responder
package aie_pkg;

   localparam int DEF_MAX_FRAME = 1514;

   localparam logic [47:0] RST_MY_MAC = 48'h020000000001;
   localparam logic [31:0] RST_MY_IP  = 32'h0a000002;

   localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
   localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ARP_OPER_REQ  = 16'h0001;
   localparam logic [7:0]  ARP_OPER_REP  = 8'h02;
   localparam logic [7:0]  IP_PROTO_ICMP = 8'h01;
   localparam logic [7:0]  ICMP_ECHO_REQ = 8'h08;
   localparam logic [3:0]  IHL_MIN       = 4'd5;

   localparam logic        OP_BYTE = 1'b0;
   localparam logic        OP_TICK = 1'b1;

   localparam logic        CSR_MY_MAC = 1'b0;
   localparam logic        CSR_MY_IP  = 1'b1;

   typedef enum logic {
      KIND_ARP,
      KIND_ECHO
   } kind_type;

   // reply descriptor handed from the receive side to the transmit side
   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [6:0]  hend;
      logic [15:0] ip_chk;
      logic [15:0] icmp_chk;
   } reply_type;

   function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
      logic [5:0] base;
      base = 6'd47 - {k, 3'b000};
      return mac[base -: 8];
   endfunction

   function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
      logic [4:0] base;
      base = 5'd31 - {k, 3'b000};
      return ip[base -: 8];
   endfunction

endpackage

// ----- rtl/arp_icmp_echo_responder.sv -----
// top level of the arp reply and icmp echo responder
//
// req channel: one transaction per item. tuser selects a frame byte (0) or a
// drain tick (1); tdata carries the frame byte, tlast marks the frame's last byte.
// Frame bytes are stored and the header fields and checksums are gathered as
// they arrive, one byte per cycle while req_tready is high. After the last
// byte the block judges the frame and holds req_tready low while it does so.
// An ARP request for my_ip or an ICMP echo request becomes a pending reply of
// the same length; bytes of new frames are dropped while it is pending.
// A drain tick with a reply pending yields one rsp transaction via the store read
// register and the output queue; ticks go one per cycle while req_tready is high.
// rsp channel: tdata is the reply byte, tlast marks its final byte. A stalled
// receiver lets at most three transactions gather in the output queue, counting
// the one being read; req_tready drops while three are queued or on their way.
// csr port: index 0 writes my_mac, index 1 writes my_ip.
// Synchronous reset empties the queue, drops any pending reply and restores
// the default addresses; frame store contents are kept.
module arp_icmp_echo_responder import aie_pkg::*; #(
   parameter int MAX_FRAME = DEF_MAX_FRAME
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   input  logic        req_tuser,  // [0] opcode
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [7:0] out_byte
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [47:0] csr_wdata
);

   localparam int CW = $clog2(MAX_FRAME + 1);
   localparam int AW = $clog2(MAX_FRAME);

   logic [47:0]   my_mac_ff;
   logic [31:0]   my_ip_ff;
   logic          acc, byte_valid, tick_valid;
   logic          judge_busy, space_ok, pending;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   reply_type     reply;
   logic [CW-1:0] reply_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         my_mac_ff <= RST_MY_MAC;
         my_ip_ff  <= RST_MY_IP;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MY_MAC: my_mac_ff <= csr_wdata;
            CSR_MY_IP:  my_ip_ff  <= csr_wdata[31:0];
            default:    my_ip_ff  <= my_ip_ff;
         endcase
      end
   end

   assign req_tready = !judge_busy && space_ok;
   assign acc        = req_tvalid && req_tready;
   assign byte_valid = acc && (req_tuser == OP_BYTE);
   assign tick_valid = acc && (req_tuser == OP_TICK);

   aie_rx #(.MAX_FRAME(MAX_FRAME)) u_rx (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (req_tdata),
      .byte_last  (req_tlast),
      .pending    (pending),
      .my_ip      (my_ip_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .judge_busy (judge_busy),
      .reply      (reply),
      .reply_len  (reply_len)
   );

   aie_tx #(.MAX_FRAME(MAX_FRAME)) u_tx (
      .clock      (clock),
      .reset      (reset),
      .tick_valid (tick_valid),
      .reply      (reply),
      .reply_len  (reply_len),
      .my_mac     (my_mac_ff),
      .my_ip      (my_ip_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .out_ready  (rsp_tready),
      .pending    (pending),
      .space_ok   (space_ok),
      .out_valid  (rsp_tvalid),
      .out_byte   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule

// ----- rtl/aie_rx.sv -----
// receive side: stores frame bytes, picks out header fields, sums checksums, judges the frame
module aie_rx import aie_pkg::*; #(
   parameter int MAX_FRAME = DEF_MAX_FRAME,
   localparam int CW = $clog2(MAX_FRAME + 1),
   localparam int AW = $clog2(MAX_FRAME)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          byte_valid,
   input  logic [7:0]    byte_data,
   input  logic          byte_last,
   input  logic          pending,
   input  logic [31:0]   my_ip,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [7:0]    wr_data,
   output logic          judge_busy,
   output reply_type     reply,
   output logic [CW-1:0] reply_len
);

   logic [CW-1:0] cnt_ff, cnt_in, len_ff, len_in;
   logic          discard_ff, discard_in, judge_ff, judge_in;
   logic [15:0]   et_ff, oper_ff, tot_ff;
   logic [31:0]   tip_ff;
   logic [7:0]    proto_ff, type_ff;
   logic [3:0]    ihl_ff;
   logic [6:0]    hend_ff;
   logic [15:0]   ipsum_ff, ipsum_in, icsum_ff, icsum_in;

   logic          take, store;
   logic          in_ip, in_ic, zero_ip, zero_ic;
   logic [15:0]   val16, ip_base, ic_base, ip_add, ic_add;
   logic [16:0]   ip_s, ic_s;
   logic [CW-1:0] hend_w;
   logic          ok_arp, ok_echo;

   assign hend_w = CW'(hend_ff);

   always_comb begin
      take  = byte_valid && !pending && !discard_ff;
      store = take && (cnt_ff < CW'(MAX_FRAME));
      val16 = cnt_ff[0] ? {8'h00, byte_data} : {byte_data, 8'h00};

      in_ip   = (cnt_ff == CW'(14)) || ((cnt_ff > CW'(14)) && (cnt_ff < hend_w));
      zero_ip = (cnt_ff == CW'(24)) || (cnt_ff == CW'(25));
      in_ic   = (cnt_ff > CW'(14)) && (cnt_ff >= hend_w) &&
                (16'(cnt_ff - CW'(14)) < tot_ff);
      zero_ic = (cnt_ff == hend_w) || (cnt_ff == hend_w + CW'(2)) ||
                (cnt_ff == hend_w + CW'(3));

      ip_add = (in_ip && !zero_ip) ? val16 : 16'h0000;
      ic_add = (in_ic && !zero_ic) ? val16 : 16'h0000;

      // a fresh frame starts its sums from zero
      ip_base = (cnt_ff == '0) ? 16'h0000 : ipsum_ff;
      ic_base = (cnt_ff == '0) ? 16'h0000 : icsum_ff;
      ip_s    = {1'b0, ip_base} + {1'b0, ip_add};
      ic_s    = {1'b0, ic_base} + {1'b0, ic_add};

      ipsum_in = ipsum_ff;
      icsum_in = icsum_ff;
      if (store) begin
         ipsum_in = ip_s[15:0] + 16'(ip_s[16]);
         icsum_in = ic_s[15:0] + 16'(ic_s[16]);
      end

      cnt_in     = cnt_ff;
      discard_in = discard_ff;
      judge_in   = 1'b0;
      len_in     = len_ff;
      if (byte_valid && (pending || discard_ff)) begin
         discard_in = !byte_last;
         cnt_in     = '0;
      end else if (take) begin
         if (byte_last) begin
            cnt_in   = '0;
            judge_in = 1'b1;
            len_in   = store ? cnt_ff + CW'(1) : cnt_ff;
         end else if (store) begin
            cnt_in = cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         discard_ff <= 1'b0;
         judge_ff   <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         discard_ff <= discard_in;
         judge_ff   <= judge_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      ipsum_ff <= ipsum_in;
      icsum_ff <= icsum_in;
      if (store) begin
         if (cnt_ff == CW'(12)) et_ff[15:8]    <= byte_data;
         if (cnt_ff == CW'(13)) et_ff[7:0]     <= byte_data;
         if (cnt_ff == CW'(14)) begin
            ihl_ff  <= byte_data[3:0];
            hend_ff <= 7'd14 + {1'b0, byte_data[3:0], 2'b00};
         end
         if (cnt_ff == CW'(16)) tot_ff[15:8]   <= byte_data;
         if (cnt_ff == CW'(17)) tot_ff[7:0]    <= byte_data;
         if (cnt_ff == CW'(20)) oper_ff[15:8]  <= byte_data;
         if (cnt_ff == CW'(21)) oper_ff[7:0]   <= byte_data;
         if (cnt_ff == CW'(23)) proto_ff       <= byte_data;
         if (cnt_ff == CW'(38)) tip_ff[31:24]  <= byte_data;
         if (cnt_ff == CW'(39)) tip_ff[23:16]  <= byte_data;
         if (cnt_ff == CW'(40)) tip_ff[15:8]   <= byte_data;
         if (cnt_ff == CW'(41)) tip_ff[7:0]    <= byte_data;
         if ((cnt_ff > CW'(14)) && (cnt_ff == hend_w)) type_ff <= byte_data;
      end
   end

   always_comb begin
      ok_arp  = (et_ff == ETH_TYPE_ARP) && (len_ff >= CW'(42)) &&
                (oper_ff == ARP_OPER_REQ) && (tip_ff == my_ip);
      ok_echo = (et_ff == ETH_TYPE_IPV4) && (len_ff >= CW'(34)) &&
                (proto_ff == IP_PROTO_ICMP) && (ihl_ff >= IHL_MIN) &&
                (len_ff >= hend_w + CW'(8)) && (type_ff == ICMP_ECHO_REQ);
      reply.valid    = judge_ff && (ok_arp || ok_echo);
      reply.kind     = ok_arp ? KIND_ARP : KIND_ECHO;
      reply.hend     = hend_ff;
      reply.ip_chk   = ~ipsum_ff;
      reply.icmp_chk = ~icsum_ff;
   end

   assign reply_len  = len_ff;
   assign judge_busy = judge_ff;
   assign wr_en      = store;
   assign wr_addr    = cnt_ff[AW-1:0];
   assign wr_data    = byte_data;

endmodule

// ----- rtl/aie_tx.sv -----
// transmit side: holds the pending reply, reads the frame store with header rewrites, output queue
module aie_tx import aie_pkg::*; #(
   parameter int MAX_FRAME = DEF_MAX_FRAME,
   localparam int CW = $clog2(MAX_FRAME + 1),
   localparam int AW = $clog2(MAX_FRAME)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          tick_valid,
   input  reply_type     reply,
   input  logic [CW-1:0] reply_len,
   input  logic [47:0]   my_mac,
   input  logic [31:0]   my_ip,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          out_ready,
   output logic          pending,
   output logic          space_ok,
   output logic          out_valid,
   output logic [7:0]    out_byte,
   output logic          out_last
);

   logic [7:0]    frame_mem_ff [MAX_FRAME];
   logic          pend_ff, pend_in;
   logic [CW-1:0] ptr_ff, ptr_in, len_ff;
   kind_type      kind_ff;
   logic [6:0]    hend_ff;
   logic [15:0]   ipchk_ff, icchk_ff;

   logic          issue, fin;
   logic [CW-1:0] p, hend_w, addr_w;
   logic          ovr;
   logic [7:0]    ovr_byte;

   logic          rd_v_ff, ovr_ff, last_ff;
   logic [7:0]    ovr_byte_ff, rdata_ff;

   logic [8:0]    q_ff [4];
   logic [1:0]    wp_ff, rp_ff;
   logic [2:0]    qcnt_ff;
   logic          push, pop;

   assign p      = ptr_ff;
   assign hend_w = CW'(hend_ff);
   assign issue  = tick_valid && pend_ff;
   assign fin    = (ptr_ff + CW'(1)) >= len_ff;

   // read address remap and rewritten header bytes
   always_comb begin
      addr_w   = p;
      ovr      = 1'b0;
      ovr_byte = 8'h00;
      if (kind_ff == KIND_ECHO) begin
         if (p < CW'(6)) begin
            addr_w = p + CW'(6);
         end else if (p < CW'(12)) begin
            addr_w = p - CW'(6);
         end else if (p == CW'(24)) begin
            ovr = 1'b1; ovr_byte = ipchk_ff[15:8];
         end else if (p == CW'(25)) begin
            ovr = 1'b1; ovr_byte = ipchk_ff[7:0];
         end else if ((p >= CW'(26)) && (p < CW'(30))) begin
            addr_w = p + CW'(4);
         end else if ((p >= CW'(30)) && (p < CW'(34))) begin
            addr_w = p - CW'(4);
         end else if (p == hend_w) begin
            ovr = 1'b1;
         end else if (p == hend_w + CW'(2)) begin
            ovr = 1'b1; ovr_byte = icchk_ff[15:8];
         end else if (p == hend_w + CW'(3)) begin
            ovr = 1'b1; ovr_byte = icchk_ff[7:0];
         end
      end else begin
         if (p < CW'(6)) begin
            addr_w = p + CW'(6);
         end else if (p < CW'(12)) begin
            ovr = 1'b1; ovr_byte = mac_byte(my_mac, 3'(p - CW'(6)));
         end else if (p == CW'(21)) begin
            ovr = 1'b1; ovr_byte = ARP_OPER_REP;
         end else if ((p >= CW'(22)) && (p < CW'(28))) begin
            ovr = 1'b1; ovr_byte = mac_byte(my_mac, 3'(p - CW'(22)));
         end else if ((p >= CW'(28)) && (p < CW'(32))) begin
            ovr = 1'b1; ovr_byte = ip_byte(my_ip, 2'(p - CW'(28)));
         end else if ((p >= CW'(32)) && (p < CW'(42))) begin
            addr_w = p - CW'(10);
         end
      end
   end

   always_comb begin
      pend_in = pend_ff;
      ptr_in  = ptr_ff;
      if (reply.valid) begin
         pend_in = 1'b1;
         ptr_in  = '0;
      end else if (issue) begin
         if (fin) begin
            pend_in = 1'b0;
            ptr_in  = '0;
         end else begin
            ptr_in = ptr_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         ptr_ff  <= '0;
         rd_v_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         ptr_ff  <= ptr_in;
         rd_v_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (reply.valid) begin
         len_ff   <= reply_len;
         kind_ff  <= reply.kind;
         hend_ff  <= reply.hend;
         ipchk_ff <= reply.ip_chk;
         icchk_ff <= reply.icmp_chk;
      end
      ovr_ff      <= ovr;
      ovr_byte_ff <= ovr_byte;
      last_ff     <= fin;
   end

   always_ff @(posedge clock) begin
      if (wr_en) frame_mem_ff[wr_addr] <= wr_data;
      rdata_ff <= frame_mem_ff[addr_w[AW-1:0]];
   end

   // output queue parts the read pipe from the receiver
   assign push = rd_v_ff;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         qcnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop)  rp_ff <= rp_ff + 2'd1;
         qcnt_ff <= qcnt_ff + 3'(push) - 3'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= {last_ff, ovr_ff ? ovr_byte_ff : rdata_ff};
   end

   assign out_valid = (qcnt_ff != 3'd0);
   assign out_byte  = q_ff[rp_ff][7:0];
   assign out_last  = q_ff[rp_ff][8];
   assign space_ok  = (qcnt_ff + 3'(rd_v_ff)) <= 3'd2;
   assign pending   = pend_ff;

endmodule

// ----- tb/tb_arp_icmp_echo_responder.sv -----
// self-checking testbench for the arp reply / icmp echo responder
module tb_arp_icmp_echo_responder;
   import aie_pkg::*;

   localparam int FRAME_MAX = DEF_MAX_FRAME;
   localparam int IDLE_LIMIT = 2000;
   localparam int ITEM_TARGET = 1600;
   localparam logic [7:0] ICMP_ECHO_REP = 8'h00;

   localparam int K_ARP = 0;
   localparam int K_ECHO = 1;
   localparam int K_OTHER = 2;

   localparam int F_NONE = 0;
   localparam int F_TARGET = 1;
   localparam int F_OPER = 2;
   localparam int F_SHORT = 3;
   localparam int F_IHL = 4;
   localparam int F_PROTO = 5;
   localparam int F_TYPE = 6;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } reply_beat_type;

   class echo_scoreboard;
      logic [47:0]    my_mac;
      logic [31:0]    my_ip;
      logic [7:0]     store [FRAME_MAX];
      int             rx_count;
      int             reply_len;
      int             tx_ptr;
      bit             reply_pending;
      bit             discarding;
      reply_beat_type reply_q [$];
      int             errors;

      function new();
         my_mac = RST_MY_MAC;
         my_ip = RST_MY_IP;
         foreach (store[i]) store[i] = 8'h00;
         rx_count = 0;
         reply_len = 0;
         tx_ptr = 0;
         reply_pending = 0;
         discarding = 0;
         errors = 0;
      endfunction

      function logic [15:0] ones_csum(int start, int n);
         logic [31:0] s;
         int i;
         s = '0;
         i = 0;
         while (i + 1 < n) begin
            s += 32'({store[start + i], store[start + i + 1]});
            i += 2;
         end
         if (i < n) s += 32'({store[start + i], 8'h00});
         while (s[31:16] != 0) s = 32'(s[15:0]) + 32'(s[31:16]);
         return ~s[15:0];
      endfunction

      function bit build_arp_reply(int len);
         logic [31:0] tip;
         if (len < 42) return 0;
         if ({store[20], store[21]} != ARP_OPER_REQ) return 0;
         tip = {store[38], store[39], store[40], store[41]};
         if (tip != my_ip) return 0;
         for (int i = 0; i < 6; i++) store[i] = store[6 + i];
         for (int i = 0; i < 6; i++) store[6 + i] = my_mac[47 - 8 * i -: 8];
         store[21] = ARP_OPER_REP;
         for (int i = 0; i < 6; i++) store[32 + i] = store[22 + i];
         for (int i = 0; i < 4; i++) store[38 + i] = store[28 + i];
         for (int i = 0; i < 6; i++) store[22 + i] = my_mac[47 - 8 * i -: 8];
         for (int i = 0; i < 4; i++) store[28 + i] = my_ip[31 - 8 * i -: 8];
         return 1;
      endfunction

      function bit build_echo_reply(int len);
         int ihl, hlen, at, tot, icmp_bytes;
         logic [7:0] t;
         logic [15:0] s;
         if (len < 34) return 0;
         if (store[23] != IP_PROTO_ICMP) return 0;
         ihl = int'(store[14][3:0]);
         if (ihl < int'(IHL_MIN)) return 0;
         hlen = ihl * 4;
         at = 14 + hlen;
         if (len < at + 8) return 0;
         if (store[at] != ICMP_ECHO_REQ) return 0;
         for (int i = 0; i < 6; i++) begin
            t = store[i]; store[i] = store[6 + i]; store[6 + i] = t;
         end
         for (int i = 0; i < 4; i++) begin
            t = store[26 + i]; store[26 + i] = store[30 + i]; store[30 + i] = t;
         end
         store[24] = 8'h00;
         store[25] = 8'h00;
         s = ones_csum(14, hlen);
         store[24] = s[15:8];
         store[25] = s[7:0];
         store[at] = ICMP_ECHO_REP;
         store[at + 2] = 8'h00;
         store[at + 3] = 8'h00;
         tot = int'({store[16], store[17]});
         icmp_bytes = tot > hlen ? tot - hlen : 0;
         if (icmp_bytes > len - at) icmp_bytes = len - at;
         s = ones_csum(at, icmp_bytes);
         store[at + 2] = s[15:8];
         store[at + 3] = s[7:0];
         return 1;
      endfunction

      function void judge_frame(int len);
         logic [15:0] et;
         bit ok;
         ok = 0;
         if (len < 14) return;
         et = {store[12], store[13]};
         if (et == ETH_TYPE_ARP) ok = build_arp_reply(len);
         else if (et == ETH_TYPE_IPV4) ok = build_echo_reply(len);
         if (ok) begin
            reply_pending = 1;
            reply_len = len;
            tx_ptr = 0;
         end
      endfunction

      function void note_input(logic op, logic [7:0] d, logic last);
         int len;
         bit fin;
         if (op == OP_TICK) begin
            if (!reply_pending) return;
            fin = tx_ptr + 1 >= reply_len;
            reply_q.push_back({store[tx_ptr], fin});
            if (fin) begin
               reply_pending = 0;
               tx_ptr = 0;
            end else begin
               tx_ptr++;
            end
            return;
         end
         // a frame touching a pending reply is dropped up to its last byte
         if (reply_pending || discarding) begin
            discarding = !last;
            rx_count = 0;
            return;
         end
         if (rx_count < FRAME_MAX) begin
            store[rx_count] = d;
            rx_count++;
         end
         if (last) begin
            len = rx_count;
            rx_count = 0;
            judge_frame(len);
         end
      endfunction

      function void check_result(logic [7:0] d, logic last);
         reply_beat_type exp_beat;
         if (reply_q.size() == 0) begin
            $error("unexpected reply transaction: out_byte %h out_last %b", d, last);
            errors++;
            return;
         end
         exp_beat = reply_q.pop_front();
         if (exp_beat.data !== d) begin
            $error("out_byte: expected %h, got %h", exp_beat.data, d);
            errors++;
         end
         if (exp_beat.last !== last) begin
            $error("out_last: expected %b, got %b", exp_beat.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic        csr_addr;
   logic [47:0] csr_wdata;

   echo_scoreboard sb;
   int  n_items;
   int  phase_len;
   int  idle_cycles;
   bit  sender_fast;
   bit  receiver_fast;

   arp_icmp_echo_responder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // transaction monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_input(req_tuser, req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // receiver with random stalls
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 63) == 0) receiver_fast = !receiver_fast;
         stall = receiver_fast ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic send_item(input logic op, input logic [7:0] d, input logic last);
      int gap;
      gap = sender_fast ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= d;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      n_items++;
   endtask

   task automatic write_reg(input logic addr, input logic [47:0] value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_MY_MAC) sb.my_mac = value;
      else sb.my_ip = value[31:0];
      @(negedge clock);
   endtask

   // hold the sender off until every reply byte has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.reply_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic send_frame(input int kind, input int ihl, input int extra, input int flaw);
      logic [7:0] f [];
      int len, at, hl, mode;
      logic [15:0] tot;
      hl = (flaw == F_IHL) ? 20 : ihl * 4;
      case (kind)
         K_ARP: len = 42 + extra;
         K_ECHO: len = 14 + hl + 8 + extra;
         default: len = extra;
      endcase
      if (flaw == F_SHORT) len = $urandom_range(14, len - 1);
      f = new[len < 100 ? 100 : len];
      foreach (f[i]) f[i] = 8'($urandom);
      if (kind == K_ARP) begin
         {f[12], f[13]} = ETH_TYPE_ARP;
         {f[20], f[21]} = ARP_OPER_REQ;
         if (flaw == F_OPER) f[21] = ARP_OPER_REP;
         {f[38], f[39], f[40], f[41]} = (flaw == F_TARGET) ? ~sb.my_ip : sb.my_ip;
      end else if (kind == K_ECHO) begin
         at = 14 + hl;
         {f[12], f[13]} = ETH_TYPE_IPV4;
         f[14][3:0] = (flaw == F_IHL) ? 4'($urandom_range(0, IHL_MIN - 1)) : 4'(ihl);
         f[23] = (flaw == F_PROTO) ? 8'h06 : IP_PROTO_ICMP;
         f[at] = (flaw == F_TYPE) ? ICMP_ECHO_REP : ICMP_ECHO_REQ;
         mode = $urandom_range(0, 3);
         case (mode)
            0: tot = 16'(len - 14);
            1: tot = 16'($urandom_range(0, hl + 8));
            2: tot = 16'(len - 14 + $urandom_range(1, 50));
            default: tot = 16'($urandom);
         endcase
         {f[16], f[17]} = tot;
      end
      for (int i = 0; i < len; i++) send_item(OP_BYTE, f[i], i == len - 1);
   endtask

   task automatic drain_reply();
      while (sb.reply_pending) begin
         // a stray byte now and then starts a discarded frame mid-reply
         if ($urandom_range(0, 49) == 0)
            send_item(OP_BYTE, 8'($urandom), $urandom_range(0, 3) == 0);
         else
            send_item(OP_TICK, 8'($urandom), 1'($urandom));
      end
   endtask

   task automatic random_frame();
      int kind, flaw, ihl;
      sender_fast = $urandom_range(0, 3) == 0;
      kind = $urandom_range(0, 9) < 4 ? K_ARP : ($urandom_range(0, 9) < 8 ? K_ECHO : K_OTHER);
      flaw = $urandom_range(0, 3) == 0 ? $urandom_range(F_TARGET, F_TYPE) : F_NONE;
      ihl = $urandom_range(0, 7) == 0 ? $urandom_range(5, 15) : $urandom_range(5, 6);
      if (kind == K_ARP && flaw > F_SHORT) flaw = F_NONE;
      send_frame(kind, ihl, kind == K_OTHER ? $urandom_range(1, 70) : $urandom_range(0, 30),
                 flaw);
      if ($urandom_range(0, 5) == 0)
         send_frame(K_ARP, 5, $urandom_range(0, 10), F_NONE);
      if ($urandom_range(0, 7) == 0) send_item(OP_TICK, 8'($urandom), 1'($urandom));
      drain_reply();
   endtask

   initial begin
      sb = new();
      n_items = 0;
      phase_len = 0;
      idle_cycles = 0;
      sender_fast = 0;
      receiver_fast = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tuser = OP_BYTE;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = CSR_MY_MAC;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed frames under reset addresses
      send_item(OP_TICK, 8'h00, 1'b0);
      send_frame(K_ARP, 5, 0, F_NONE);
      drain_reply();
      send_frame(K_ARP, 5, 18, F_TARGET);
      send_frame(K_ARP, 5, 5, F_OPER);
      send_frame(K_ARP, 5, 0, F_SHORT);
      send_frame(K_ECHO, 5, 0, F_NONE);
      drain_reply();
      send_frame(K_ECHO, 15, 9, F_NONE);
      drain_reply();
      send_frame(K_ECHO, 5, 3, F_IHL);
      send_frame(K_ECHO, 6, 0, F_SHORT);
      send_frame(K_ECHO, 5, 11, F_PROTO);
      send_frame(K_ECHO, 5, 7, F_TYPE);
      send_frame(K_OTHER, 5, 1, F_NONE);
      send_frame(K_OTHER, 5, 13, F_NONE);
      send_frame(K_OTHER, 5, 60, F_NONE);
      send_frame(K_ARP, 5, 2, F_NONE);
      drain_reply();
      send_item(OP_TICK, 8'hff, 1'b1);
      settle();

      // the remaining items are split over three address settings
      phase_len = (ITEM_TARGET - n_items) / 3;

      write_reg(CSR_MY_MAC, 48'h0);
      write_reg(CSR_MY_IP, 48'h0);
      while (n_items < ITEM_TARGET - 2 * phase_len) random_frame();
      settle();

      write_reg(CSR_MY_MAC, 48'hffff_ffff_ffff);
      write_reg(CSR_MY_IP, 48'hffff_ffff);
      while (n_items < ITEM_TARGET - phase_len) random_frame();
      settle();

      write_reg(CSR_MY_MAC, 48'({$urandom, $urandom}));
      write_reg(CSR_MY_IP, {16'h0, $urandom});
      while (n_items < ITEM_TARGET) random_frame();

      settle();
      repeat (20) @(negedge clock);
      if (sb.reply_q.size() != 0) begin
         $error("%0d reply transactions never arrived", sb.reply_q.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/aie_pkg.sv
rtl/aie_rx.sv
rtl/aie_tx.sv
rtl/arp_icmp_echo_responder.sv
tb/tb_arp_icmp_echo_responder.sv
